// File: design/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types, codes and the known-tag table of the dynamic tag collector.
// ----------------------------------------------------------------------------
`default_nettype none

package dtc_pkg;

    localparam int unsigned TAG_SLOTS = 20;
    localparam int unsigned TAG_DEPTH = 2 * TAG_SLOTS;
    localparam int unsigned TAG_AW    = 6;
    localparam logic [4:0]  NO_SLOT   = 5'd20;
    localparam logic [16:0] ENTRY_CAP = 17'd65536;

    // opcodes
    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_ENTRY   = 3'd1;
    localparam logic [2:0] OP_CLOSE   = 3'd2;
    localparam logic [2:0] OP_RD_TAG  = 3'd3;
    localparam logic [2:0] OP_RD_NEED = 3'd4;

    // result status codes
    localparam logic [3:0] ST_STORED     = 4'd0;
    localparam logic [3:0] ST_CONFLICT   = 4'd1;
    localparam logic [3:0] ST_NEEDED     = 4'd2;
    localparam logic [3:0] ST_NEEDED_OVF = 4'd3;
    localparam logic [3:0] ST_UNKNOWN    = 4'd4;
    localparam logic [3:0] ST_TERMINATOR = 4'd5;
    localparam logic [3:0] ST_IGNORED    = 4'd6;
    localparam logic [3:0] ST_OPENED     = 4'd7;
    localparam logic [3:0] ST_OPENED_MIS = 4'd8;
    localparam logic [3:0] ST_OUTSIDE    = 4'd9;
    localparam logic [3:0] ST_UNTERM     = 4'd10;
    localparam logic [3:0] ST_COMMITTED  = 4'd11;
    localparam logic [3:0] ST_EXTRA_TERM = 4'd12;
    localparam logic [3:0] ST_READ       = 4'd13;

    // DT_* tags held in slots 0..19
    localparam logic [63:0] KNOWN_TAGS [TAG_SLOTS] = '{
        64'd2,  64'd3,  64'd4,  64'd5,  64'd6,  64'd7,  64'd8,  64'd9,
        64'd10, 64'd11, 64'd12, 64'd13, 64'd17, 64'd18, 64'd19, 64'd20,
        64'd23, 64'd25, 64'd27, 64'h6fff_fef5
    };

    typedef enum logic [1:0] {
        DSEL_ZERO = 2'd0,
        DSEL_VAL  = 2'd1,
        DSEL_TAG  = 2'd2,
        DSEL_NEED = 2'd3
    } dsel_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [63:0] entry_tag;
        logic [63:0]        entry_value;
        logic [63:0]        segment_bytes;
        logic               segment_in_file;
        logic [5:0]         read_index;
    } in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [4:0]  slot;
        logic [63:0] data;
        logic        data_valid;
        logic [23:0] entry_total;
        logic [15:0] segment_count;
        logic [6:0]  needed_count;
        logic        needed_overflow;
        logic        found;
        logic        terminated;
    } out_t;

    // word in flight between the state update and the result stage
    typedef struct packed {
        logic [3:0]  status;
        logic [4:0]  slot;
        dsel_t       dsel;
        logic        cmp;       // repeat of a held tag: compare with RAM data
        logic [63:0] val;
        logic        dvalid;
        logic [23:0] entry_total;
        logic [15:0] segment_count;
        logic [6:0]  needed_count;
        logic        needed_overflow;
        logic        found;
        logic        terminated;
    } stage_t;

    function automatic logic [4:0] slot_of(input logic [63:0] tag);
        logic [4:0] s;
        s = NO_SLOT;
        for (int i = TAG_SLOTS - 1; i >= 0; i--) begin
            if (tag == KNOWN_TAGS[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    function automatic logic [TAG_AW-1:0] tag_addr(input logic bank, input logic [4:0] s);
        return bank ? (TAG_AW'(s) + TAG_AW'(TAG_SLOTS)) : TAG_AW'(s);
    endfunction

endpackage

`default_nettype wire

// File: design/dtc_ram.sv
// ----------------------------------------------------------------------------
// dtc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/dtc_front.sv
// ----------------------------------------------------------------------------
// dtc_front
// Segment / bank control state; decides each word and issues RAM accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_front #(
    parameter int NEEDED_DEPTH = 64,
    localparam int NAW = $clog2(2 * NEEDED_DEPTH),
    localparam int FW  = $clog2(NEEDED_DEPTH + 1),
    localparam int CW  = (FW > 6) ? FW : 6
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [16:0]                    cfg_wdata,
    input  wire logic                           accept,
    input  wire dtc_pkg::in_t                   in_word,
    output dtc_pkg::stage_t                     stage,
    output logic                                tag_we,
    output logic [dtc_pkg::TAG_AW-1:0]          tag_waddr,
    output logic [63:0]                         tag_wdata,
    output logic                                tag_re,
    output logic [dtc_pkg::TAG_AW-1:0]          tag_raddr,
    output logic                                need_we,
    output logic [NAW-1:0]                      need_waddr,
    output logic [63:0]                         need_wdata,
    output logic                                need_re,
    output logic [NAW-1:0]                      need_raddr
);

    logic [16:0]          max_entries_reg;
    logic [1:0][19:0]     valid_reg, valid_next;
    logic [FW-1:0]        fill_reg [2];
    logic [FW-1:0]        fill_next [2];
    logic [1:0]           lost_reg, lost_next;
    logic                 work_bank_reg, work_bank_next;
    logic                 kept_bank_reg, kept_bank_next;
    logic                 kept_reg, kept_next;
    logic                 seen_reg, seen_next;
    logic                 open_reg, open_next;
    logic                 ended_reg, ended_next;
    logic [16:0]          left_reg, left_next;
    logic [23:0]          entries_reg, entries_next;
    logic [15:0]          segs_reg, segs_next;

    logic [16:0]          lim;
    logic [59:0]          avail;
    logic [16:0]          seg_limit;
    logic [4:0]           tslot;
    logic [4:0]           rd_slot;
    logic [FW-1:0]        fill_sel;

    assign lim       = (max_entries_reg > dtc_pkg::ENTRY_CAP) ? dtc_pkg::ENTRY_CAP
                                                              : max_entries_reg;
    assign avail     = in_word.segment_bytes[63:4];
    assign seg_limit = (|avail[59:17]) ? lim
                     : ((avail[16:0] < lim) ? avail[16:0] : lim);
    assign tslot     = dtc_pkg::slot_of($unsigned(in_word.entry_tag));
    assign rd_slot   = in_word.read_index[4:0];

    always_comb begin
        valid_next     = valid_reg;
        fill_next      = fill_reg;
        lost_next      = lost_reg;
        work_bank_next = work_bank_reg;
        kept_bank_next = kept_bank_reg;
        kept_next      = kept_reg;
        seen_next      = seen_reg;
        open_next      = open_reg;
        ended_next     = ended_reg;
        left_next      = left_reg;
        entries_next   = entries_reg;
        segs_next      = segs_reg;

        tag_we     = 1'b0;
        tag_waddr  = dtc_pkg::tag_addr(work_bank_reg, tslot);
        tag_wdata  = in_word.entry_value;
        tag_re     = 1'b0;
        tag_raddr  = dtc_pkg::tag_addr(work_bank_reg, tslot);
        need_we    = 1'b0;
        need_waddr = (work_bank_reg ? NAW'(NEEDED_DEPTH) : NAW'(0))
                   + NAW'(fill_reg[work_bank_reg]);
        need_wdata = in_word.entry_value;
        need_re    = 1'b0;
        need_raddr = (kept_bank_reg ? NAW'(NEEDED_DEPTH) : NAW'(0))
                   + NAW'(in_word.read_index);

        stage        = '0;
        stage.status = dtc_pkg::ST_IGNORED;
        stage.slot   = dtc_pkg::NO_SLOT;
        stage.dsel   = dtc_pkg::DSEL_ZERO;
        stage.val    = in_word.entry_value;

        if (accept) begin
            unique case (in_word.opcode)
                dtc_pkg::OP_OPEN: begin
                    seen_next  = 1'b1;
                    if (segs_reg != '1) begin
                        segs_next = segs_reg + 16'd1;
                    end
                    open_next  = 1'b0;
                    ended_next = 1'b0;
                    left_next  = '0;
                    if (!in_word.segment_in_file) begin
                        stage.status = dtc_pkg::ST_OUTSIDE;
                    end else begin
                        work_bank_next             = ~kept_bank_reg;
                        valid_next[~kept_bank_reg] = '0;
                        fill_next[~kept_bank_reg]  = '0;
                        lost_next[~kept_bank_reg]  = 1'b0;
                        left_next                  = seg_limit;
                        open_next                  = 1'b1;
                        stage.status = (|in_word.segment_bytes[3:0])
                                     ? dtc_pkg::ST_OPENED_MIS : dtc_pkg::ST_OPENED;
                    end
                end
                dtc_pkg::OP_ENTRY: begin
                    if (open_reg && !ended_reg && (left_reg != '0)) begin
                        left_next = left_reg - 17'd1;
                        if (entries_reg != '1) begin
                            entries_next = entries_reg + 24'd1;
                        end
                        if (in_word.entry_tag == 64'sd0) begin
                            ended_next   = 1'b1;
                            stage.status = dtc_pkg::ST_TERMINATOR;
                        end else if (in_word.entry_tag == 64'sd1) begin
                            if (fill_reg[work_bank_reg] < FW'(NEEDED_DEPTH)) begin
                                need_we                  = 1'b1;
                                fill_next[work_bank_reg] = fill_reg[work_bank_reg] + FW'(1);
                                stage.dsel               = dtc_pkg::DSEL_VAL;
                                stage.status             = dtc_pkg::ST_NEEDED;
                            end else begin
                                lost_next[work_bank_reg] = 1'b1;
                                stage.status             = dtc_pkg::ST_NEEDED_OVF;
                            end
                        end else if (tslot == dtc_pkg::NO_SLOT) begin
                            stage.status = dtc_pkg::ST_UNKNOWN;
                        end else begin
                            stage.slot = tslot;
                            if (!valid_reg[work_bank_reg][tslot]) begin
                                tag_we                            = 1'b1;
                                valid_next[work_bank_reg][tslot]  = 1'b1;
                                stage.status                      = dtc_pkg::ST_STORED;
                                stage.dsel                        = dtc_pkg::DSEL_VAL;
                            end else begin
                                // result stage decides stored vs conflict from RAM
                                tag_re     = 1'b1;
                                stage.cmp  = 1'b1;
                                stage.dsel = dtc_pkg::DSEL_TAG;
                            end
                        end
                    end
                end
                dtc_pkg::OP_CLOSE: begin
                    if (open_reg) begin
                        open_next = 1'b0;
                        if (!ended_reg) begin
                            stage.status = dtc_pkg::ST_UNTERM;
                        end else if (!kept_reg) begin
                            kept_bank_next = work_bank_reg;
                            kept_next      = 1'b1;
                            stage.status   = dtc_pkg::ST_COMMITTED;
                        end else begin
                            stage.status = dtc_pkg::ST_EXTRA_TERM;
                        end
                        ended_next = 1'b0;
                        left_next  = '0;
                    end
                end
                dtc_pkg::OP_RD_TAG: begin
                    stage.status = dtc_pkg::ST_READ;
                    tag_raddr    = dtc_pkg::tag_addr(kept_bank_reg, rd_slot);
                    if (in_word.read_index < 6'(dtc_pkg::TAG_SLOTS)) begin
                        stage.slot = rd_slot;
                        if (kept_reg && valid_reg[kept_bank_reg][rd_slot]) begin
                            tag_re       = 1'b1;
                            stage.dsel   = dtc_pkg::DSEL_TAG;
                            stage.dvalid = 1'b1;
                        end
                    end
                end
                dtc_pkg::OP_RD_NEED: begin
                    stage.status = dtc_pkg::ST_READ;
                    if (kept_reg
                        && (CW'(in_word.read_index) < CW'(fill_reg[kept_bank_reg]))
                        && (CW'(in_word.read_index) < CW'(NEEDED_DEPTH))) begin
                        need_re      = 1'b1;
                        stage.dsel   = dtc_pkg::DSEL_NEED;
                        stage.dvalid = 1'b1;
                    end
                end
                default: begin
                    stage.status = dtc_pkg::ST_IGNORED;
                end
            endcase
        end

        // status fields reflect the state after this word
        fill_sel                = fill_next[kept_bank_next];
        stage.entry_total       = entries_next;
        stage.segment_count     = segs_next;
        stage.found             = seen_next;
        stage.terminated        = kept_next;
        stage.needed_count      = !kept_next ? 7'd0
                                : ((32'(fill_sel) > 32'd127) ? 7'd127 : 7'(fill_sel));
        stage.needed_overflow   = kept_next & lost_next[kept_bank_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= dtc_pkg::ENTRY_CAP;
            valid_reg       <= '0;
            fill_reg        <= '{default: '0};
            lost_reg        <= '0;
            work_bank_reg   <= 1'b0;
            kept_bank_reg   <= 1'b0;
            kept_reg        <= 1'b0;
            seen_reg        <= 1'b0;
            open_reg        <= 1'b0;
            ended_reg       <= 1'b0;
            left_reg        <= '0;
            entries_reg     <= '0;
            segs_reg        <= '0;
        end else begin
            if (cfg_we) begin
                max_entries_reg <= cfg_wdata;
            end
            valid_reg     <= valid_next;
            fill_reg      <= fill_next;
            lost_reg      <= lost_next;
            work_bank_reg <= work_bank_next;
            kept_bank_reg <= kept_bank_next;
            kept_reg      <= kept_next;
            seen_reg      <= seen_next;
            open_reg      <= open_next;
            ended_reg     <= ended_next;
            left_reg      <= left_next;
            entries_reg   <= entries_next;
            segs_reg      <= segs_next;
        end
    end

endmodule

`default_nettype wire

// File: design/dtc_back.sv
// ----------------------------------------------------------------------------
// dtc_back
// Result stage: merges RAM read data into the word and holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire dtc_pkg::stage_t stage_in,
    input  wire logic [63:0]     tag_rdata,
    input  wire logic [63:0]     need_rdata,
    input  wire logic            m_ready,
    output logic                 m_valid,
    output dtc_pkg::out_t        m_data,
    output logic                 p1_busy,
    output logic                 out_free
);

    dtc_pkg::stage_t p1_reg;
    logic            p1_valid_reg;
    logic            m_valid_reg;
    dtc_pkg::out_t   m_data_reg;
    dtc_pkg::out_t   result;

    assign out_free = !m_valid_reg || m_ready;
    assign p1_busy  = p1_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        result.slot            = p1_reg.slot;
        result.data_valid      = p1_reg.dvalid;
        result.entry_total     = p1_reg.entry_total;
        result.segment_count   = p1_reg.segment_count;
        result.needed_count    = p1_reg.needed_count;
        result.needed_overflow = p1_reg.needed_overflow;
        result.found           = p1_reg.found;
        result.terminated      = p1_reg.terminated;
        case (p1_reg.dsel)
            dtc_pkg::DSEL_VAL:  result.data = p1_reg.val;
            dtc_pkg::DSEL_TAG:  result.data = tag_rdata;
            dtc_pkg::DSEL_NEED: result.data = need_rdata;
            default:            result.data = '0;
        endcase
        if (p1_reg.cmp) begin
            result.status = (tag_rdata != p1_reg.val) ? dtc_pkg::ST_CONFLICT
                                                      : dtc_pkg::ST_STORED;
        end else begin
            result.status = p1_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (out_free) begin
                p1_valid_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= stage_in;
        end
        if (out_free && p1_valid_reg) begin
            m_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: design/dynamic_tag_collector.sv
// ----------------------------------------------------------------------------
// dynamic_tag_collector
// Collects 64-bit ELF dynamic entries into a candidate bank and commits the
// first terminated dynamic segment; answers reads of the committed bank.
// ----------------------------------------------------------------------------
// Throughput is one word per clock on s_ and m_ while m_ready stays high;
// each word's result sits in the result stage beside its RAM read data, then
// in the output register. Segment control, valid bits and needed-list fill
// counts sit in flip-flops and are updated in the cycle a word is taken; the
// tag values (2 banks x 20 slots) and the needed list (2 x NEEDED_DEPTH) live
// in two RAMs. A new tag is written in its own cycle and a repeat reads the
// held value for the conflict compare, so back-to-back words on one slot see
// the write without forwarding. The stores need no clearing pass: slots are
// read only behind their valid bit and the list only below its fill count,
// so the block takes words right out of reset. max_entries (cfg_data) is to
// be written while idle (block does not enforce); reset value and cap 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_tag_collector #(
    parameter int NEEDED_DEPTH = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // configuration: max_entries
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [16:0]   cfg_data,
    // input words
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire dtc_pkg::in_t  s_data,
    // result words
    output logic               m_valid,
    input  wire logic          m_ready,
    output dtc_pkg::out_t      m_data
);

    localparam int NAW = $clog2(2 * NEEDED_DEPTH);

    logic                         accept;
    logic                         p1_busy;
    logic                         out_free;
    dtc_pkg::stage_t              stage;

    logic                         tag_we, tag_re;
    logic [dtc_pkg::TAG_AW-1:0]   tag_waddr, tag_raddr;
    logic [63:0]                  tag_wdata, tag_rdata;
    logic                         need_we, need_re;
    logic [NAW-1:0]               need_waddr, need_raddr;
    logic [63:0]                  need_wdata, need_rdata;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // the result stage frees up whenever the output register moves
    assign s_ready = !p1_busy || out_free;
    assign accept  = s_valid && s_ready;

    dtc_front #(
        .NEEDED_DEPTH (NEEDED_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_wdata  (cfg_data),
        .accept     (accept),
        .in_word    (s_data),
        .stage      (stage),
        .tag_we     (tag_we),
        .tag_waddr  (tag_waddr),
        .tag_wdata  (tag_wdata),
        .tag_re     (tag_re),
        .tag_raddr  (tag_raddr),
        .need_we    (need_we),
        .need_waddr (need_waddr),
        .need_wdata (need_wdata),
        .need_re    (need_re),
        .need_raddr (need_raddr)
    );

    // tag values: bank 0 at 0..19, bank 1 at 20..39
    dtc_ram #(
        .WIDTH (64),
        .DEPTH (dtc_pkg::TAG_DEPTH)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    // needed list: bank 0 first, bank 1 at NEEDED_DEPTH
    dtc_ram #(
        .WIDTH (64),
        .DEPTH (2 * NEEDED_DEPTH)
    ) u_need_ram (
        .aclk  (aclk),
        .we    (need_we),
        .waddr (need_waddr),
        .wdata (need_wdata),
        .re    (need_re),
        .raddr (need_raddr),
        .rdata (need_rdata)
    );

    dtc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .stage_in   (stage),
        .tag_rdata  (tag_rdata),
        .need_rdata (need_rdata),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_data     (m_data),
        .p1_busy    (p1_busy),
        .out_free   (out_free)
    );

    // a taken word always occupies the result stage next cycle
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_busy)
        else $error("accepted word lost before result stage");

    // a commit implies a segment was seen
    a_commit_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.terminated |-> m_data.found)
        else $error("committed bank without any segment");

    // with nothing committed the needed summary is empty
    a_no_commit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.terminated |-> (m_data.needed_count == 7'd0)
                                          && !m_data.needed_overflow)
        else $error("needed summary without committed bank");

    // only reads return data_valid
    a_dvalid_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.data_valid |-> (m_data.status == dtc_pkg::ST_READ)
                                         && m_data.terminated)
        else $error("data_valid on a non-read result");

endmodule

`default_nettype wire
